// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RHHT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RHHT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define RHHT_ASSERT(label, clk, rst, prop, msg)
`define RHHT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

// ===== rtl/core/rhht_pkg.sv =====
// Types and constants of the Robin Hood hash table.
package rhht_pkg;

   localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME  = 32'd16777619;
   localparam logic [6:0]  LIMIT_RESET = 7'd70;
   localparam logic [6:0]  PCT_SCALE   = 7'd100;

   typedef enum logic [1:0] {
      CMD_SET  = 2'd0,
      CMD_GET  = 2'd1,
      CMD_DEL  = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STAT_INSERTED  = 3'd0,
      STAT_UPDATED   = 3'd1,
      STAT_FOUND     = 3'd2,
      STAT_NOT_FOUND = 3'd3,
      STAT_DELETED   = 3'd4,
      STAT_FULL      = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      MARK_EMPTY = 2'd0,
      MARK_LIVE  = 2'd1,
      MARK_TOMB  = 2'd2
   } mark_type;

   typedef struct packed {
      logic [63:0] key;
      logic [31:0] value;
      logic [31:0] hash;
      mark_type    mark;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_READ,
      ST_EVAL,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic hash;
      logic read;
      logic eval;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic hash_last;
      logic skip;
      logic probe_done;
   } dp_stat_type;

endpackage

// ===== rtl/core/rhht_ctrl.sv =====
// Sequencer for clear pass, hashing, probing and response.
module rhht_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  rhht_pkg::dp_stat_type stat,
   output rhht_pkg::ctl_cmd_type cmd,
   output logic                  busy,
   output logic                  rsp_valid
);
   import rhht_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            cmd.hash = 1'b1;
            if (stat.hash_last) state_in = stat.skip ? ST_RESP : ST_READ;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = stat.probe_done ? ST_RESP : ST_READ;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/core/rhht_dp.sv =====
// Slot memory, FNV-1a hash unit, probe logic and counters.
module rhht_dp #(
   parameter int SLOTS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rhht_pkg::ctl_cmd_type cmd,
   output rhht_pkg::dp_stat_type stat,
   input  logic                  csr_we,
   input  logic [6:0]            csr_wdata,
   input  logic [1:0]            req_cmd,
   input  logic [63:0]           req_key,
   input  logic [31:0]           req_value,
   output logic [2:0]            rsp_status,
   output logic [31:0]           rsp_read_value,
   output logic [6:0]            rsp_entry_count
);
   import rhht_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int PW    = CNT_W + 8;

   entry_type mem [SLOTS];
   entry_type rd_ff;

   logic [6:0]       limit_ff;
   logic [CNT_W-1:0] live_ff, live_in, tomb_ff, tomb_in;
   logic [IDX_W-1:0] idx_ff, probe_ff;
   logic [1:0]       op_ff;
   logic [63:0]      ck_ff;
   logic [31:0]      cv_ff, ch_ff, h_next;
   logic [2:0]       hb_ff;
   logic             newc_ff, full_ff;
   status_type       status_ff, status_in;
   logic [31:0]      rdval_ff, rdval_in;

   logic [63:0]      canon;
   logic             going;
   logic [CNT_W:0]   used;
   logic [PW-1:0]    prod;
   logic             full_now;

   logic             we;
   entry_type        wdata;
   logic             done, swap;
   logic [IDX_W-1:0] dist_slot, dist_car;
   logic             last, match;
   logic [7:0]       hbyte;

   always_comb begin
      canon = '0;
      going = 1'b1;
      for (int b = 0; b < 8; b++) begin
         if (req_key[8*b +: 8] == 8'd0) going = 1'b0;
         if (going) canon[8*b +: 8] = req_key[8*b +: 8];
      end
   end

   always_comb begin
      used     = {1'b0, live_ff} + {1'b0, tomb_ff};
      prod     = PW'(used + 1'b1) * PW'(PCT_SCALE);
      full_now = (used >= (CNT_W+1)'(SLOTS)) || ((prod >> IDX_W) > PW'(limit_ff));
   end

   assign hbyte  = ck_ff[8*hb_ff +: 8];
   assign h_next = (hbyte == 8'd0) ? ch_ff : 32'((ch_ff ^ {24'd0, hbyte}) * FNV_PRIME);

   assign dist_slot = idx_ff - rd_ff.hash[IDX_W-1:0];
   assign dist_car  = idx_ff - ch_ff[IDX_W-1:0];
   assign last      = (probe_ff == {IDX_W{1'b1}});
   assign match     = (rd_ff.hash == ch_ff) && (rd_ff.key == ck_ff);

   always_comb begin
      we        = 1'b0;
      wdata     = '{key: ck_ff, value: cv_ff, hash: ch_ff, mark: MARK_LIVE};
      done      = 1'b0;
      swap      = 1'b0;
      live_in   = live_ff;
      tomb_in   = tomb_ff;
      status_in = status_ff;
      rdval_in  = rdval_ff;
      if (cmd.load) begin
         status_in = ((req_cmd == CMD_SET) && full_now) ? STAT_FULL : STAT_NOT_FOUND;
         rdval_in  = '0;
      end else if (cmd.clear) begin
         we         = 1'b1;
         wdata.mark = MARK_EMPTY;
      end else if (cmd.eval) begin
         case (op_ff)
            CMD_SET: begin
               if (rd_ff.mark != MARK_LIVE) begin
                  we        = 1'b1;
                  done      = 1'b1;
                  live_in   = live_ff + 1'b1;
                  if (rd_ff.mark == MARK_TOMB) tomb_in = tomb_ff - 1'b1;
                  status_in = STAT_INSERTED;
               end else if (newc_ff && match) begin
                  we        = 1'b1;
                  wdata.key = rd_ff.key;
                  done      = 1'b1;
                  status_in = STAT_UPDATED;
               end else begin
                  if (dist_car > dist_slot) begin
                     we   = 1'b1;
                     swap = 1'b1;
                  end
                  done = last;
                  if (last) status_in = STAT_FULL;
               end
            end
            CMD_GET, CMD_DEL: begin
               if (rd_ff.mark == MARK_EMPTY) begin
                  done = 1'b1;
               end else if (rd_ff.mark == MARK_LIVE && probe_ff > dist_slot) begin
                  done = 1'b1;
               end else if (rd_ff.mark == MARK_LIVE && match) begin
                  done = 1'b1;
                  if (op_ff == CMD_GET) begin
                     status_in = STAT_FOUND;
                     rdval_in  = rd_ff.value;
                  end else begin
                     we         = 1'b1;
                     wdata      = rd_ff;
                     wdata.mark = MARK_TOMB;
                     live_in    = live_ff - 1'b1;
                     tomb_in    = tomb_ff + 1'b1;
                     status_in  = STAT_DELETED;
                  end
               end else begin
                  done = last;
               end
            end
            default: done = 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[idx_ff] <= wdata;
      if (cmd.read) rd_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         live_ff  <= '0;
         tomb_ff  <= '0;
         idx_ff   <= '0;
      end else begin
         if (csr_we) limit_ff <= csr_wdata;
         live_ff <= live_in;
         tomb_ff <= tomb_in;
         if (cmd.clear || (cmd.eval && !done)) idx_ff <= idx_ff + 1'b1;
         else if (cmd.hash && hb_ff == 3'd7) idx_ff <= h_next[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      rdval_ff  <= rdval_in;
      if (cmd.load) begin
         op_ff     <= req_cmd;
         ck_ff     <= canon;
         cv_ff     <= req_value;
         ch_ff     <= FNV_OFFSET;
         hb_ff     <= 3'd0;
         probe_ff  <= '0;
         newc_ff   <= 1'b1;
         full_ff   <= (req_cmd == CMD_SET) && full_now;
      end
      if (cmd.hash) begin
         ch_ff <= h_next;
         hb_ff <= hb_ff + 1'b1;
      end
      if (cmd.eval && !done) probe_ff <= probe_ff + 1'b1;
      if (swap) begin
         ck_ff   <= rd_ff.key;
         cv_ff   <= rd_ff.value;
         ch_ff   <= rd_ff.hash;
         newc_ff <= 1'b0;
      end
   end

   assign stat.clear_last = cmd.clear && (idx_ff == {IDX_W{1'b1}});
   assign stat.hash_last  = (hb_ff == 3'd7);
   assign stat.skip       = full_ff || (op_ff == CMD_NONE);
   assign stat.probe_done = done;

   assign rsp_status      = status_ff;
   assign rsp_read_value  = rdval_ff;
   assign rsp_entry_count = 7'(live_ff);

endmodule

// ===== rtl/core/robin_hood_hash_table.sv =====
// Robin Hood hash table top level.
//
//  channel   ports                                  transfer
//  request   start, busy, req_cmd/key/value         start high while busy low
//  response  rsp_valid, rsp_status/read_value/...   rsp_valid high, one cycle
//  config    csr_we, csr_wdata                      csr_we high
//
// After reset a clearing pass marks every slot empty; busy stays high meanwhile.
// After acceptance the key is hashed, one key byte per multiply, then each probed
// slot takes a registered slot memory read, then an evaluate and write step;
// a response state ends the item. The next transfer is taken only back in idle,
// so a new item is never accepted before the last one has been answered.
// Unused commands and full sets skip probing. The response cannot be stalled.
`include "assert_macros.svh"
module robin_hood_hash_table #(
   parameter int SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [63:0] req_key,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_read_value,
   output logic [6:0]  rsp_entry_count,
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata
);
   import rhht_pkg::*;

   ctl_cmd_type ctl_cmd;
   dp_stat_type dp_stat;

   rhht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (dp_stat),
      .cmd       (ctl_cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   rhht_dp #(.SLOTS(SLOTS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (ctl_cmd),
      .stat            (dp_stat),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .req_cmd         (req_cmd),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_count (rsp_entry_count)
   );

   `RHHT_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy, "accept did not raise busy")
   `RHHT_ASSERT(a_rsp_busy, clock, reset, rsp_valid |-> busy, "response outside busy")
   `RHHT_NEVER(a_status_range, clock, reset, rsp_valid && (rsp_status > STAT_FULL), "bad status")
   `RHHT_ASSERT(a_rdval_zero, clock, reset,
      (rsp_valid && rsp_status != STAT_FOUND) |-> (rsp_read_value == 32'd0), "stray read value")

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench of the Robin Hood hash table: directed and random set/get/delete.
module tb;
   import rhht_pkg::*;

   localparam int          NSLOT      = 64;
   localparam int          LIMIT      = 1_000_000;
   localparam int          POOL       = 24;

   typedef struct {
      status_type  status;
      logic [31:0] read_value;
      logic [6:0]  entry_count;
   } outcome_type;

   logic        clock, reset, start, busy, rsp_valid, csr_we;
   logic [1:0]  req_cmd;
   logic [63:0] req_key;
   logic [31:0] req_value;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_read_value;
   logic [6:0]  rsp_entry_count;
   logic [6:0]  csr_wdata;

   robin_hood_hash_table dut (
      .clock, .reset, .start, .busy, .req_cmd, .req_key, .req_value,
      .rsp_valid, .rsp_status, .rsp_read_value, .rsp_entry_count,
      .csr_we, .csr_wdata
   );

   // table mirror
   logic [63:0] tbl_key  [NSLOT];
   logic [31:0] tbl_val  [NSLOT];
   logic [31:0] tbl_hash [NSLOT];
   mark_type    tbl_mark [NSLOT];
   int          n_live, n_tomb;
   logic [6:0]  load_pct;

   outcome_type pending_outcomes[$];
   logic [63:0] key_pool[POOL];
   int          errors, cycles, sent, status_seen[8];
   int          gap_pct;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [63:0] trim_key(logic [63:0] k);
      logic [63:0] r;
      r = '0;
      for (int b = 0; b < 8; b++) begin
         if (k[8*b +: 8] == 8'h00) break;
         r[8*b +: 8] = k[8*b +: 8];
      end
      return r;
   endfunction

   function automatic logic [31:0] fnv_hash(logic [63:0] k);
      logic [31:0] h;
      h = FNV_OFFSET;
      for (int b = 0; b < 8; b++) begin
         if (k[8*b +: 8] == 8'h00) break;
         h = (h ^ {24'd0, k[8*b +: 8]}) * FNV_PRIME;
      end
      return h;
   endfunction

   function automatic int home_gap(logic [31:0] h, int s);
      return (s + NSLOT - int'(h[5:0])) % NSLOT;
   endfunction

   function automatic int locate(logic [63:0] k, logic [31:0] h);
      int idx;
      for (int i = 0; i < NSLOT; i++) begin
         idx = (int'(h[5:0]) + i) % NSLOT;
         if (tbl_mark[idx] == MARK_EMPTY) return -1;
         if (tbl_mark[idx] == MARK_LIVE) begin
            if (i > home_gap(tbl_hash[idx], idx)) return -1;
            if (tbl_hash[idx] == h && tbl_key[idx] == k) return idx;
         end
      end
      return -1;
   endfunction

   function automatic status_type table_set(logic [63:0] k, logic [31:0] h, logic [31:0] v);
      logic [63:0] ck, tk;
      logic [31:0] cv, ch, tv, th;
      bit          carrying;
      int          idx, used;
      ck = k; cv = v; ch = h; carrying = 1;
      used = n_live + n_tomb;
      if (used >= NSLOT || (used + 1) * 100 / NSLOT > int'(load_pct)) return STAT_FULL;
      for (int i = 0; i < NSLOT; i++) begin
         idx = (int'(h[5:0]) + i) % NSLOT;
         if (tbl_mark[idx] != MARK_LIVE) begin
            if (tbl_mark[idx] == MARK_TOMB) n_tomb--;
            tbl_key[idx] = ck; tbl_val[idx] = cv; tbl_hash[idx] = ch;
            tbl_mark[idx] = MARK_LIVE;
            n_live++;
            return STAT_INSERTED;
         end
         if (carrying && tbl_hash[idx] == ch && tbl_key[idx] == ck) begin
            tbl_val[idx] = cv;
            return STAT_UPDATED;
         end
         if (home_gap(ch, idx) > home_gap(tbl_hash[idx], idx)) begin
            tk = tbl_key[idx]; tv = tbl_val[idx]; th = tbl_hash[idx];
            tbl_key[idx] = ck; tbl_val[idx] = cv; tbl_hash[idx] = ch;
            ck = tk; cv = tv; ch = th;
            carrying = 0;
         end
      end
      return STAT_FULL;
   endfunction

   task automatic predict_op(logic [1:0] cmd, logic [63:0] raw, logic [31:0] v);
      logic [63:0] k;
      logic [31:0] h;
      outcome_type o;
      int          s;
      k = trim_key(raw);
      h = fnv_hash(k);
      o.status = STAT_NOT_FOUND;
      o.read_value = '0;
      if (cmd == CMD_SET) begin
         o.status = table_set(k, h, v);
      end else if (cmd == CMD_GET) begin
         s = locate(k, h);
         if (s >= 0) begin
            o.status = STAT_FOUND;
            o.read_value = tbl_val[s];
         end
      end else if (cmd == CMD_DEL) begin
         s = locate(k, h);
         if (s >= 0) begin
            tbl_mark[s] = MARK_TOMB;
            n_live--;
            n_tomb++;
            o.status = STAT_DELETED;
         end
      end
      o.entry_count = 7'(n_live);
      pending_outcomes.push_back(o);
   endtask

   always @(posedge clock) begin
      outcome_type o;
      if (!reset && rsp_valid) begin
         if (pending_outcomes.size() == 0) begin
            $error("unexpected result transfer, status %0d", rsp_status);
            errors++;
         end else begin
            o = pending_outcomes.pop_front();
            status_seen[rsp_status]++;
            if (rsp_status !== o.status) begin
               $error("status: expected %0d, got %0d", o.status, rsp_status);
               errors++;
            end
            if (rsp_read_value !== o.read_value) begin
               $error("read_value: expected %h, got %h", o.read_value, rsp_read_value);
               errors++;
            end
            if (rsp_entry_count !== o.entry_count) begin
               $error("entry_count: expected %0d, got %0d", o.entry_count, rsp_entry_count);
               errors++;
            end
         end
      end
   end

   function automatic logic [63:0] make_key();
      logic [63:0] k;
      int          len;
      k = {$urandom, $urandom};
      len = $urandom_range(8);
      for (int b = 0; b < len; b++)
         if (k[8*b +: 8] == 8'h00) k[8*b +: 8] = 8'($urandom_range(1, 255));
      if (len < 8) k[8*len +: 8] = 8'h00;
      return k;
   endfunction

   // same key, fresh bytes after the terminator
   function automatic logic [63:0] rescramble_tail(logic [63:0] k);
      logic [63:0] r;
      int          len;
      r = k;
      len = 8;
      for (int b = 7; b >= 0; b--)
         if (k[8*b +: 8] == 8'h00) len = b;
      for (int b = len + 1; b < 8; b++) r[8*b +: 8] = 8'($urandom);
      return r;
   endfunction

   // sender idles in about gap_pct of the cycles in which it could transfer
   task automatic send_op(logic [1:0] cmd, logic [63:0] k, logic [31:0] v);
      bit go;
      req_cmd   <= cmd;
      req_key   <= k;
      req_value <= v;
      do begin
         go = !(gap_pct > 0 && $urandom_range(99) < gap_pct);
         start <= go;
         @(posedge clock);
      end while (!(go && !busy));
      predict_op(cmd, k, v);
      sent++;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_outcomes.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(logic [6:0] pct);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= pct;
      @(posedge clock);
      load_pct = pct;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_directed();
      send_op(CMD_GET, key_pool[0], '0);
      send_op(CMD_DEL, key_pool[0], '0);
      send_op(CMD_NONE, key_pool[0], 32'hFFFF_FFFF);
      send_op(CMD_SET, 64'd0, 32'hFFFF_FFFF);
      send_op(CMD_GET, 64'hFFFF_FFFF_FFFF_FF00, '0);
      send_op(CMD_SET, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
      send_op(CMD_SET, 64'hFFFF_FFFF_FFFF_FFFF, 32'hA5A5_5A5A);
      send_op(CMD_GET, 64'hFFFF_FFFF_FFFF_FFFF, '0);
      send_op(CMD_SET, 64'h0000_0000_0000_0001, 32'h1);
      send_op(CMD_GET, 64'hDEAD_BEEF_0000_0001, '0);
      send_op(CMD_SET, key_pool[1], 32'h1234_5678);
      send_op(CMD_NONE, key_pool[1], '0);
      send_op(CMD_DEL, rescramble_tail(key_pool[1]), '0);
      send_op(CMD_GET, key_pool[1], '0);
      send_op(CMD_DEL, key_pool[1], '0);
      send_op(CMD_SET, key_pool[1], 32'h8765_4321);
      send_op(CMD_GET, key_pool[1], '0);
      send_op(CMD_DEL, 64'd0, '0);
      send_op(CMD_GET, 64'd0, '0);
      send_op(CMD_SET, 64'd0, 32'h7);
   endtask

   task automatic test_limit_low();
      write_limit(7'd1);
      send_op(CMD_SET, key_pool[1], 32'h1);
      send_op(CMD_SET, key_pool[2], 32'h2);
      send_op(CMD_GET, key_pool[1], '0);
      write_limit(7'd0);
      send_op(CMD_SET, key_pool[3], 32'h3);
      send_op(CMD_DEL, key_pool[1], '0);
   endtask

   task automatic test_random(int n, int idle);
      int          r;
      logic [1:0]  cmd;
      logic [63:0] k;
      gap_pct = idle;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         cmd = r < 45 ? CMD_SET : r < 75 ? CMD_GET : r < 95 ? CMD_DEL : CMD_NONE;
         k = $urandom_range(9) == 0 ? make_key()
                                    : rescramble_tail(key_pool[$urandom_range(POOL - 1)]);
         send_op(cmd, k, $urandom);
      end
   endtask

   task automatic test_fill();
      write_limit(7'd100);
      for (int i = 0; i < 70; i++) send_op(CMD_SET, make_key(), $urandom);
      for (int i = 0; i < 8; i++) send_op(CMD_GET, key_pool[i], '0);
      write_limit(7'd127);
      send_op(CMD_SET, make_key(), $urandom);
      send_op(CMD_SET, key_pool[0], $urandom);
   endtask

   initial begin
      reset = 1; start = 0; csr_we = 0; csr_wdata = '0;
      req_cmd = CMD_SET; req_key = '0; req_value = '0;
      errors = 0; cycles = 0; sent = 0; gap_pct = 0;
      n_live = 0; n_tomb = 0; load_pct = LIMIT_RESET;
      foreach (tbl_mark[i]) tbl_mark[i] = MARK_EMPTY;
      foreach (status_seen[i]) status_seen[i] = 0;
      foreach (key_pool[i]) key_pool[i] = make_key();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_limit_low();
      write_limit(7'd90);
      test_random(570, 11);
      write_limit(7'($urandom_range(60, 100)));
      test_random(570, 51);
      write_limit(7'd100);
      test_random(570, 0);
      test_fill();
      drain();
      repeat (20) @(posedge clock);
      $display("Sent %0d operations in %0d cycles: inserted %0d, updated %0d, found %0d,",
               sent, cycles, status_seen[STAT_INSERTED], status_seen[STAT_UPDATED],
               status_seen[STAT_FOUND]);
      $display("  not found %0d, deleted %0d, full %0d; load limits 70, 1, 0, 90, 60-100, 100, 127.",
               status_seen[STAT_NOT_FOUND], status_seen[STAT_DELETED], status_seen[STAT_FULL]);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/rhht_pkg.sv
rtl/core/rhht_ctrl.sv
rtl/core/rhht_dp.sv
rtl/core/robin_hood_hash_table.sv
tb/sv/tb.sv
